// ===== hdl/awb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Affine warp package
// Shared sizes, register indexes, queue entry type and blend constants.
// ----------------------------------------------------------------------------
package awb_pkg;

	localparam int SRC_MAX_W = 256;
	localparam int SRC_MAX_H = 256;
	localparam int FRAC_BITS = 16;

	localparam int XW        = $clog2(SRC_MAX_W);
	localparam int YW        = $clog2(SRC_MAX_H);
	localparam int AW        = XW + YW;
	localparam int COEF_W    = 32;
	localparam int POS_W     = 10;
	localparam int PIX_W     = 32;
	localparam int DIM_W     = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int PROD_W    = COEF_W + POS_W + 1;
	localparam int SUM_W     = PROD_W + 2;
	localparam int FLOOR_W   = SUM_W - FRAC_BITS;
	localparam int CH_W      = 8;
	localparam int NCH       = PIX_W / CH_W;
	localparam int MIX1_W    = CH_W + FRAC_BITS;
	localparam int MIX2_W    = CH_W + 2 * FRAC_BITS;
	localparam int FIFO_AW   = 2;
	localparam int RES_SLOTS = 3;

	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_XX    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YY    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd7;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_RENDER = 1'b1;

	typedef enum logic [2:0] {
		KIND_LOAD    = 3'b001,
		KIND_RENDER  = 3'b010,
		KIND_OUTSIDE = 3'b100
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [XW-1:0]        x;
		logic [YW-1:0]        y;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
		logic [PIX_W-1:0]     pixel;
	} entry_t;

endpackage
`default_nettype wire

// ===== hdl/awb_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Affine warp channel interfaces
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface awb_item_if;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [awb_pkg::POS_W-1:0] pos_x;
	logic [awb_pkg::POS_W-1:0] pos_y;
	logic [awb_pkg::PIX_W-1:0] pixel_in;
	modport source (output valid, command, pos_x, pos_y, pixel_in, input ready);
	modport sink (input valid, command, pos_x, pos_y, pixel_in, output ready);
endinterface

interface awb_result_if;
	logic                      valid;
	logic                      ready;
	logic [awb_pkg::PIX_W-1:0] pixel_out;
	logic                      outside;
	modport source (output valid, pixel_out, outside, input ready);
	modport sink (input valid, pixel_out, outside, output ready);
endinterface

interface awb_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [awb_pkg::CFG_IDX_W-1:0] index;
	logic [awb_pkg::CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/affine_warp_bilinear_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Affine warp with bilinear sampling
// Top level: front end, work queue and sampling back end.
// ----------------------------------------------------------------------------
// The cfg channel writes the matrix, offsets and source size; it is always
// ready. It must be written only while the block is idle; the block
// itself does not enforce this. The item channel takes load words, which
// store one source pixel and give no result, and render words, which give
// one result word on the result channel: the blended RGBA pixel, or zero
// with the outside flag set.
// A word enters every cycle while the queue has room. The front end
// registers the position products and then their sum. In the back end a
// load and an outside render need no RAM read, while an inside render reads
// its four neighbors one after another on the single pixel RAM port; that
// port sets the sustained rate of inside renders.
// When the receiver stalls, the result register holds its word, the blend
// stages and queue fill, and then the item channel drops ready. Reset clears
// the configuration to the identity map at 256 by 256 and empties all
// stages; pixel memory contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module affine_warp_bilinear_top (
	input  wire logic      clk,
	input  wire logic      arst_n,
	awb_cfg_if.sink        cfg,
	awb_item_if.sink       item,
	awb_result_if.source   result
);
	logic             push_valid, push_ready, head_valid, pop;
	awb_pkg::entry_t  push_data, head;

	awb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	awb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.head_valid(head_valid),
		.pop       (pop),
		.head      (head)
	);

	awb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.result    (result)
	);
endmodule
`default_nettype wire

// ===== hdl/awb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module awb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== hdl/awb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Affine warp front end
// Holds the configuration, maps render words to source positions and
// classifies every word before it enters the work queue.
// ----------------------------------------------------------------------------
module awb_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	awb_cfg_if.sink               cfg,
	awb_item_if.sink              item,
	output logic                  push_valid,
	input  wire logic             push_ready,
	output awb_pkg::entry_t       push_data
);
	logic signed [awb_pkg::COEF_W-1:0] coef_xx_q, coef_xy_q, offset_x_q;
	logic signed [awb_pkg::COEF_W-1:0] coef_yx_q, coef_yy_q, offset_y_q;
	logic [awb_pkg::DIM_W-1:0]         src_width_q, src_height_q;

	logic                              v_s1, v_s2;
	logic                              cmd_s1, cmd_s2;
	logic [awb_pkg::POS_W-1:0]         px_s1, py_s1, px_s2, py_s2;
	logic [awb_pkg::PIX_W-1:0]         pix_s1, pix_s2;
	logic signed [awb_pkg::PROD_W-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1;
	logic signed [awb_pkg::SUM_W-1:0]  sx_s2, sy_s2;

	logic signed [awb_pkg::PROD_W-1:0] px_e, py_e;
	logic [awb_pkg::DIM_W-1:0]         w_eff, h_eff;
	logic [awb_pkg::FLOOR_W-1:0]       flx, fly;
	logic                              is_out, load_ok, en1, en2;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q    <= 32'sd65536;
			coef_xy_q    <= '0;
			offset_x_q   <= '0;
			coef_yx_q    <= '0;
			coef_yy_q    <= 32'sd65536;
			offset_y_q   <= '0;
			src_width_q  <= awb_pkg::DIM_W'(256);
			src_height_q <= awb_pkg::DIM_W'(256);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				awb_pkg::REG_COEF_XX:    coef_xx_q    <= cfg.data;
				awb_pkg::REG_COEF_XY:    coef_xy_q    <= cfg.data;
				awb_pkg::REG_OFFSET_X:   offset_x_q   <= cfg.data;
				awb_pkg::REG_COEF_YX:    coef_yx_q    <= cfg.data;
				awb_pkg::REG_COEF_YY:    coef_yy_q    <= cfg.data;
				awb_pkg::REG_OFFSET_Y:   offset_y_q   <= cfg.data;
				awb_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg.data[awb_pkg::DIM_W-1:0];
				awb_pkg::REG_SRC_HEIGHT: src_height_q <= cfg.data[awb_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign px_e = awb_pkg::PROD_W'($signed({1'b0, item.pos_x}));
	assign py_e = awb_pkg::PROD_W'($signed({1'b0, item.pos_y}));

	always_comb begin
		w_eff = (32'(src_width_q) > 32'(awb_pkg::SRC_MAX_W)) ?
			awb_pkg::DIM_W'(awb_pkg::SRC_MAX_W) : src_width_q;
		h_eff = (32'(src_height_q) > 32'(awb_pkg::SRC_MAX_H)) ?
			awb_pkg::DIM_W'(awb_pkg::SRC_MAX_H) : src_height_q;
		flx = sx_s2[awb_pkg::SUM_W-1:awb_pkg::FRAC_BITS];
		fly = sy_s2[awb_pkg::SUM_W-1:awb_pkg::FRAC_BITS];
		is_out = sx_s2[awb_pkg::SUM_W-1] || sy_s2[awb_pkg::SUM_W-1] ||
			(({1'b0, flx} + 1'b1) >= (awb_pkg::FLOOR_W + 1)'(w_eff)) ||
			(({1'b0, fly} + 1'b1) >= (awb_pkg::FLOOR_W + 1)'(h_eff));
		load_ok = (32'(px_s2) < 32'(awb_pkg::SRC_MAX_W)) &&
			(32'(py_s2) < 32'(awb_pkg::SRC_MAX_H));

		push_data.pixel = pix_s2;
		push_data.fx    = sx_s2[awb_pkg::FRAC_BITS-1:0];
		push_data.fy    = sy_s2[awb_pkg::FRAC_BITS-1:0];
		if (cmd_s2 == awb_pkg::CMD_LOAD) begin
			push_data.kind = awb_pkg::KIND_LOAD;
			push_data.x    = awb_pkg::XW'(px_s2);
			push_data.y    = awb_pkg::YW'(py_s2);
		end else begin
			push_data.kind = is_out ? awb_pkg::KIND_OUTSIDE : awb_pkg::KIND_RENDER;
			push_data.x    = flx[awb_pkg::XW-1:0];
			push_data.y    = fly[awb_pkg::YW-1:0];
		end
		push_valid = v_s2 && ((cmd_s2 == awb_pkg::CMD_RENDER) || load_ok);
		en2 = !v_s2 || !push_valid || push_ready;
		en1 = !v_s1 || en2;
	end

	assign item.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= item.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && item.valid) begin
			cmd_s1 <= item.command;
			px_s1  <= item.pos_x;
			py_s1  <= item.pos_y;
			pix_s1 <= item.pixel_in;
			pxx_s1 <= awb_pkg::PROD_W'(coef_xx_q) * px_e;
			pxy_s1 <= awb_pkg::PROD_W'(coef_xy_q) * py_e;
			pyx_s1 <= awb_pkg::PROD_W'(coef_yx_q) * px_e;
			pyy_s1 <= awb_pkg::PROD_W'(coef_yy_q) * py_e;
		end
		if (en2 && v_s1) begin
			cmd_s2 <= cmd_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			pix_s2 <= pix_s1;
			sx_s2  <= awb_pkg::SUM_W'(pxx_s1) + awb_pkg::SUM_W'(pxy_s1) +
				awb_pkg::SUM_W'(offset_x_q);
			sy_s2  <= awb_pkg::SUM_W'(pyx_s1) + awb_pkg::SUM_W'(pyy_s1) +
				awb_pkg::SUM_W'(offset_y_q);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/awb_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Affine warp work queue
// Short queue between the front end and the sampling back end.
// ----------------------------------------------------------------------------
module awb_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire awb_pkg::entry_t  push_data,
	output logic                  head_valid,
	input  wire logic             pop,
	output awb_pkg::entry_t       head
);
	awb_pkg::entry_t             slot_q [2**awb_pkg::FIFO_AW];
	logic [awb_pkg::FIFO_AW:0]   wr_q, rd_q;

	assign head_valid = (wr_q != rd_q);
	assign push_ready = (wr_q[awb_pkg::FIFO_AW] == rd_q[awb_pkg::FIFO_AW]) ||
		(wr_q[awb_pkg::FIFO_AW-1:0] != rd_q[awb_pkg::FIFO_AW-1:0]);
	assign head = slot_q[rd_q[awb_pkg::FIFO_AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push_valid && push_ready) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && head_valid) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			slot_q[wr_q[awb_pkg::FIFO_AW-1:0]] <= push_data;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/awb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Affine warp back end
// Stores loaded pixels, fetches the four neighbors of a render word and
// blends them through a two-stage multiply pipeline into the result register.
// ----------------------------------------------------------------------------
module awb_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire awb_pkg::entry_t  head,
	output logic                  pop,
	awb_result_if.source          result
);
	logic                              we, re, start, last;
	logic [awb_pkg::AW-1:0]            addr;
	logic [awb_pkg::PIX_W-1:0]         rdata;
	logic [1:0]                        cnt_q, inflight_q;
	logic                              room, out_take;

	logic                              rd_v_s1, arr_s1, arr_out_s1;
	logic [1:0]                        rd_sel_s1;
	logic [awb_pkg::FRAC_BITS-1:0]     fx_s1, fy_s1;
	logic [awb_pkg::PIX_W-1:0]         p00_q, p10_q, p01_q;

	logic                              g_v_q, g_out_q;
	logic [awb_pkg::PIX_W-1:0]         g_p00_q, g_p10_q, g_p01_q, g_p11_q;
	logic [awb_pkg::FRAC_BITS-1:0]     g_fx_q, g_fy_q;

	logic                              m1_v_q, m1_out_q;
	logic [awb_pkg::FRAC_BITS-1:0]     m1_fy_q;
	logic [awb_pkg::MIX1_W-1:0]        top_q [awb_pkg::NCH];
	logic [awb_pkg::MIX1_W-1:0]        bot_q [awb_pkg::NCH];

	logic                              out_v_q, out_side_q;
	logic [awb_pkg::PIX_W-1:0]         out_pix_q;
	logic                              out_en, m1_en;
	logic [awb_pkg::FRAC_BITS:0]       omfx, omfy;

	awb_ram #(
		.WIDTH(awb_pkg::PIX_W),
		.DEPTH(awb_pkg::SRC_MAX_W * awb_pkg::SRC_MAX_H)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(head.pixel),
		.rdata(rdata)
	);

	assign room     = (32'(inflight_q) < awb_pkg::RES_SLOTS);
	assign out_take = out_v_q && result.ready;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		pop   = 1'b0;
		start = 1'b0;
		last  = 1'b0;
		addr  = {head.y, head.x};
		if (head_valid) begin
			unique case (head.kind)
				awb_pkg::KIND_LOAD: begin
					we  = 1'b1;
					pop = 1'b1;
				end
				awb_pkg::KIND_RENDER: begin
					addr = {head.y + awb_pkg::YW'(cnt_q[1]), head.x + awb_pkg::XW'(cnt_q[0])};
					if ((cnt_q != 2'd0) || room) begin
						re    = 1'b1;
						start = (cnt_q == 2'd0);
						last  = (cnt_q == 2'd3);
						pop   = last;
					end
				end
				awb_pkg::KIND_OUTSIDE: begin
					if (room) begin
						start = 1'b1;
						last  = 1'b1;
						pop   = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			inflight_q <= '0;
			rd_v_s1    <= 1'b0;
			arr_s1     <= 1'b0;
		end else begin
			if (re) begin
				cnt_q <= cnt_q + 1'b1;
			end
			inflight_q <= inflight_q + 2'(start) - 2'(out_take);
			rd_v_s1    <= re;
			arr_s1     <= last;
		end
	end

	always_ff @(posedge clk) begin
		rd_sel_s1  <= cnt_q;
		arr_out_s1 <= (head.kind == awb_pkg::KIND_OUTSIDE);
		fx_s1      <= head.fx;
		fy_s1      <= head.fy;
		if (rd_v_s1) begin
			case (rd_sel_s1)
				2'd0:    p00_q <= rdata;
				2'd1:    p10_q <= rdata;
				2'd2:    p01_q <= rdata;
				default: ;
			endcase
		end
	end

	assign out_en = !out_v_q || result.ready;
	assign m1_en  = !m1_v_q || out_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_v_q   <= 1'b0;
			m1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (arr_s1) begin
				g_v_q <= 1'b1;
			end else if (m1_en) begin
				g_v_q <= 1'b0;
			end
			if (m1_en) begin
				m1_v_q <= g_v_q;
			end
			if (out_en) begin
				out_v_q <= m1_v_q;
			end
		end
	end

	assign omfx = awb_pkg::ONE - (awb_pkg::FRAC_BITS + 1)'(g_fx_q);
	assign omfy = awb_pkg::ONE - (awb_pkg::FRAC_BITS + 1)'(m1_fy_q);

	always_ff @(posedge clk) begin
		if (arr_s1) begin
			g_p00_q <= p00_q;
			g_p10_q <= p10_q;
			g_p01_q <= p01_q;
			g_p11_q <= rdata;
			g_fx_q  <= fx_s1;
			g_fy_q  <= fy_s1;
			g_out_q <= arr_out_s1;
		end
		if (m1_en && g_v_q) begin
			m1_out_q <= g_out_q;
			m1_fy_q  <= g_fy_q;
			for (int c = 0; c < awb_pkg::NCH; c++) begin
				top_q[c] <=
					awb_pkg::MIX1_W'(g_p00_q[c*awb_pkg::CH_W +: awb_pkg::CH_W]) *
					awb_pkg::MIX1_W'(omfx) +
					awb_pkg::MIX1_W'(g_p10_q[c*awb_pkg::CH_W +: awb_pkg::CH_W]) *
					awb_pkg::MIX1_W'(g_fx_q);
				bot_q[c] <=
					awb_pkg::MIX1_W'(g_p01_q[c*awb_pkg::CH_W +: awb_pkg::CH_W]) *
					awb_pkg::MIX1_W'(omfx) +
					awb_pkg::MIX1_W'(g_p11_q[c*awb_pkg::CH_W +: awb_pkg::CH_W]) *
					awb_pkg::MIX1_W'(g_fx_q);
			end
		end
		if (out_en && m1_v_q) begin
			out_side_q <= m1_out_q;
			for (int c = 0; c < awb_pkg::NCH; c++) begin
				out_pix_q[c*awb_pkg::CH_W +: awb_pkg::CH_W] <= m1_out_q ? '0 :
					awb_pkg::CH_W'((awb_pkg::MIX2_W'(top_q[c]) * awb_pkg::MIX2_W'(omfy) +
					awb_pkg::MIX2_W'(bot_q[c]) * awb_pkg::MIX2_W'(m1_fy_q)) >>
					(2 * awb_pkg::FRAC_BITS));
			end
		end
	end

	assign result.valid     = out_v_q;
	assign result.pixel_out = out_pix_q;
	assign result.outside   = out_side_q;
endmodule
`default_nettype wire

// ===== hdl/awb_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Affine warp port checker
// Checks the result channel as seen at the top level ports.
// ----------------------------------------------------------------------------
module awb_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic [awb_pkg::PIX_W-1:0] pixel_out,
	input wire logic                      outside
);
	a_idle_in_reset: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result word shown during reset");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(pixel_out) && $stable(outside))
		else $error("stalled result word changed");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && outside |-> pixel_out == '0)
		else $error("outside result word carries a pixel");
endmodule

bind affine_warp_bilinear_top awb_checker u_awb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.pixel_out(result.pixel_out),
	.outside  (result.outside)
);
`default_nettype wire

// ===== tb/warp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Affine warp result checker
// Watches the configuration, input and result channels. It keeps its own
// copy of the matrix, the source size and the pixel store, predicts each
// render word, and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module warp_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	awb_item_if       item,
	awb_cfg_if        cfg,
	awb_result_if     result,
	output int        errors,
	output int        pending,
	output int        renders,
	output int        inside_hits,
	output int        loads
);

	typedef struct {
		logic [awb_pkg::PIX_W-1:0] pixel;
		logic                      outside;
	} warp_result_t;

	localparam longint unsigned UNIT = 64'd1 << awb_pkg::FRAC_BITS;

	longint                    m_xx, m_xy, m_ox, m_yx, m_yy, m_oy;
	int                        size_w, size_h;
	logic [awb_pkg::PIX_W-1:0] pixel_store [awb_pkg::SRC_MAX_W*awb_pkg::SRC_MAX_H];
	warp_result_t              expected_pixels [$];

	function automatic warp_result_t predict_warp(logic [awb_pkg::POS_W-1:0] col,
		logic [awb_pkg::POS_W-1:0] row);
		warp_result_t              r;
		longint                    sx, sy, fxl, fyl, ww, hh;
		longint unsigned           fx, fy, a, b, c, d, upper, lower, v;
		logic [awb_pkg::PIX_W-1:0] p00, p10, p01, p11;
		r.pixel   = '0;
		r.outside = 1'b1;
		sx = m_xx * longint'(col) + m_xy * longint'(row) + m_ox;
		sy = m_yx * longint'(col) + m_yy * longint'(row) + m_oy;
		ww = (size_w > awb_pkg::SRC_MAX_W) ? longint'(awb_pkg::SRC_MAX_W) : longint'(size_w);
		hh = (size_h > awb_pkg::SRC_MAX_H) ? longint'(awb_pkg::SRC_MAX_H) : longint'(size_h);
		if (sx < 0 || sy < 0)
			return r;
		fxl = sx >>> awb_pkg::FRAC_BITS;
		fyl = sy >>> awb_pkg::FRAC_BITS;
		if (fxl + 1 >= ww || fyl + 1 >= hh)
			return r;
		fx = longint'(sx) & (UNIT - 1);
		fy = longint'(sy) & (UNIT - 1);
		p00 = pixel_store[fyl * awb_pkg::SRC_MAX_W + fxl];
		p10 = pixel_store[fyl * awb_pkg::SRC_MAX_W + fxl + 1];
		p01 = pixel_store[(fyl + 1) * awb_pkg::SRC_MAX_W + fxl];
		p11 = pixel_store[(fyl + 1) * awb_pkg::SRC_MAX_W + fxl + 1];
		for (int ch = 0; ch < awb_pkg::NCH; ch++) begin
			a = p00[ch*awb_pkg::CH_W +: awb_pkg::CH_W];
			b = p10[ch*awb_pkg::CH_W +: awb_pkg::CH_W];
			c = p01[ch*awb_pkg::CH_W +: awb_pkg::CH_W];
			d = p11[ch*awb_pkg::CH_W +: awb_pkg::CH_W];
			upper = a * (UNIT - fx) + b * fx;
			lower = c * (UNIT - fx) + d * fx;
			v = (upper * (UNIT - fy) + lower * fy) >> (2 * awb_pkg::FRAC_BITS);
			r.pixel[ch*awb_pkg::CH_W +: awb_pkg::CH_W] = v[awb_pkg::CH_W-1:0];
		end
		r.outside = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		warp_result_t e;
		if (!arst_n) begin
			m_xx = 65536; m_xy = 0; m_ox = 0;
			m_yx = 0; m_yy = 65536; m_oy = 0;
			size_w = 256; size_h = 256;
			expected_pixels.delete();
			errors = 0; pending = 0; renders = 0; inside_hits = 0; loads = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					awb_pkg::REG_COEF_XX:    m_xx = longint'($signed(cfg.data));
					awb_pkg::REG_COEF_XY:    m_xy = longint'($signed(cfg.data));
					awb_pkg::REG_OFFSET_X:   m_ox = longint'($signed(cfg.data));
					awb_pkg::REG_COEF_YX:    m_yx = longint'($signed(cfg.data));
					awb_pkg::REG_COEF_YY:    m_yy = longint'($signed(cfg.data));
					awb_pkg::REG_OFFSET_Y:   m_oy = longint'($signed(cfg.data));
					awb_pkg::REG_SRC_WIDTH:  size_w = int'(cfg.data[awb_pkg::DIM_W-1:0]);
					awb_pkg::REG_SRC_HEIGHT: size_h = int'(cfg.data[awb_pkg::DIM_W-1:0]);
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("result word with no render pending: pixel_out %h outside %b",
						result.pixel_out, result.outside);
					errors++;
				end else begin
					e = expected_pixels.pop_front();
					if (result.pixel_out !== e.pixel) begin
						$error("pixel_out: expected %h, actual %h", e.pixel, result.pixel_out);
						errors++;
					end
					if (result.outside !== e.outside) begin
						$error("outside: expected %b, actual %b", e.outside, result.outside);
						errors++;
					end
				end
			end
			if (item.valid && item.ready) begin
				if (item.command == awb_pkg::CMD_LOAD) begin
					loads++;
					if (item.pos_x < awb_pkg::SRC_MAX_W && item.pos_y < awb_pkg::SRC_MAX_H)
						pixel_store[item.pos_y * awb_pkg::SRC_MAX_W + item.pos_x] =
							item.pixel_in;
				end else begin
					e = predict_warp(item.pos_x, item.pos_y);
					renders++;
					if (!e.outside)
						inside_hits++;
					expected_pixels.push_back(e);
				end
			end
			pending = expected_pixels.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Affine warp testbench top
// Runs phases of configuration, source loads and renders with random gaps
// and result stalls; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

	logic clk;
	logic arst_n;
	bit   calm;
	int   errors, pending, renders, inside_hits, loads;
	int   sent;

	logic [awb_pkg::CFG_DAT_W-1:0] reg_mirror [8];
	bit                            loaded [awb_pkg::SRC_MAX_W*awb_pkg::SRC_MAX_H];

	awb_item_if   item();
	awb_result_if result();
	awb_cfg_if    cfg();

	affine_warp_bilinear_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

	warp_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cfg         (cfg),
		.result      (result),
		.errors      (errors),
		.pending     (pending),
		.renders     (renders),
		.inside_hits (inside_hits),
		.loads       (loads)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(negedge clk)
		result.ready <= calm || ($urandom_range(0, 99) >= 13);

	// An inside render must never touch a source pixel that was never loaded.
	function automatic bit hits_unloaded(logic [awb_pkg::POS_W-1:0] col,
		logic [awb_pkg::POS_W-1:0] row);
		longint sx, sy, fxl, fyl, ww, hh;
		sx = longint'($signed(reg_mirror[awb_pkg::REG_COEF_XX])) * longint'(col)
			+ longint'($signed(reg_mirror[awb_pkg::REG_COEF_XY])) * longint'(row)
			+ longint'($signed(reg_mirror[awb_pkg::REG_OFFSET_X]));
		sy = longint'($signed(reg_mirror[awb_pkg::REG_COEF_YX])) * longint'(col)
			+ longint'($signed(reg_mirror[awb_pkg::REG_COEF_YY])) * longint'(row)
			+ longint'($signed(reg_mirror[awb_pkg::REG_OFFSET_Y]));
		ww = longint'(reg_mirror[awb_pkg::REG_SRC_WIDTH][awb_pkg::DIM_W-1:0]);
		hh = longint'(reg_mirror[awb_pkg::REG_SRC_HEIGHT][awb_pkg::DIM_W-1:0]);
		if (ww > awb_pkg::SRC_MAX_W) ww = awb_pkg::SRC_MAX_W;
		if (hh > awb_pkg::SRC_MAX_H) hh = awb_pkg::SRC_MAX_H;
		if (sx < 0 || sy < 0)
			return 1'b0;
		fxl = sx >>> awb_pkg::FRAC_BITS;
		fyl = sy >>> awb_pkg::FRAC_BITS;
		if (fxl + 1 >= ww || fyl + 1 >= hh)
			return 1'b0;
		return !(loaded[fyl*awb_pkg::SRC_MAX_W + fxl]
			&& loaded[fyl*awb_pkg::SRC_MAX_W + fxl + 1]
			&& loaded[(fyl+1)*awb_pkg::SRC_MAX_W + fxl]
			&& loaded[(fyl+1)*awb_pkg::SRC_MAX_W + fxl + 1]);
	endfunction

	function automatic logic [awb_pkg::CFG_DAT_W-1:0] random_coef();
		int unsigned mag;
		if ($urandom_range(0, 9) == 0)
			return $urandom();
		mag = $urandom_range(0, 98304);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	task automatic write_reg(input logic [awb_pkg::CFG_IDX_W-1:0] idx,
		input logic [awb_pkg::CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		reg_mirror[idx] = val;
	endtask

	task automatic send_word(input logic cmd, input logic [awb_pkg::POS_W-1:0] x,
		input logic [awb_pkg::POS_W-1:0] y, input logic [awb_pkg::PIX_W-1:0] pix);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 13) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item.valid    <= 1'b1;
		item.command  <= cmd;
		item.pos_x    <= x;
		item.pos_y    <= y;
		item.pixel_in <= pix;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		if (cmd == awb_pkg::CMD_LOAD && x < awb_pkg::SRC_MAX_W && y < awb_pkg::SRC_MAX_H)
			loaded[y*awb_pkg::SRC_MAX_W + x] = 1'b1;
		sent++;
	endtask

	task automatic render_if_safe(input logic [awb_pkg::POS_W-1:0] col,
		input logic [awb_pkg::POS_W-1:0] row);
		if (!hits_unloaded(col, row))
			send_word(awb_pkg::CMD_RENDER, col, row, $urandom());
	endtask

	task automatic run_phase(input int phase);
		logic [awb_pkg::CFG_DAT_W-1:0] v [8];
		int lw, lh;
		@(negedge clk);
		item.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		case (phase)
			0: v = reg_mirror;
			1: v = '{32'd65536, 32'd0, 32'h8000, 32'd0, 32'd65536, 32'h4000, 32'd6, 32'd5};
			2: v = '{32'h7FFFFFFF, 32'h80000000, 32'd0, 32'h80000000, 32'h7FFFFFFF,
				32'hFFFFFFFF, 32'd511, 32'd300};
			3: v = '{32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0};
			4: v = '{32'd65536, 32'd0, 32'h1234, 32'd0, 32'd65536, 32'd0, 32'd1, 32'd8};
			5: v = '{32'd32768, 32'd0, 32'd0, 32'd0, 32'd32768, 32'd0, 32'd256, 32'd256};
			default: begin
				v[awb_pkg::REG_SRC_WIDTH]  = ($urandom_range(0, 9) == 0)
					? $urandom_range(0, 511) : $urandom_range(2, 12);
				v[awb_pkg::REG_SRC_HEIGHT] = ($urandom_range(0, 9) == 0)
					? $urandom_range(0, 511) : $urandom_range(2, 12);
				v[awb_pkg::REG_COEF_XX]  = random_coef();
				v[awb_pkg::REG_COEF_XY]  = random_coef();
				v[awb_pkg::REG_COEF_YX]  = random_coef();
				v[awb_pkg::REG_COEF_YY]  = random_coef();
				v[awb_pkg::REG_OFFSET_X] = $urandom_range(0, 12 << awb_pkg::FRAC_BITS);
				v[awb_pkg::REG_OFFSET_Y] = $urandom_range(0, 12 << awb_pkg::FRAC_BITS);
			end
		endcase
		if (phase != 0)
			for (int i = 0; i < 8; i++)
				write_reg(i[awb_pkg::CFG_IDX_W-1:0], v[i]);
		calm = (phase == 6 || phase == 7);
		lw = int'(reg_mirror[awb_pkg::REG_SRC_WIDTH][awb_pkg::DIM_W-1:0]);
		lh = int'(reg_mirror[awb_pkg::REG_SRC_HEIGHT][awb_pkg::DIM_W-1:0]);
		if (lw > 12) lw = 12;
		if (lh > 12) lh = 12;
		if (phase == 0) begin
			lw = 3;
			lh = 3;
		end
		for (int y = 0; y < lh; y++)
			for (int x = 0; x < lw; x++)
				send_word(awb_pkg::CMD_LOAD, awb_pkg::POS_W'(x), awb_pkg::POS_W'(y),
					(phase == 0) ? (((x + y) % 2) ? '1 : '0) : $urandom());
		if (phase == 0) begin
			render_if_safe(awb_pkg::POS_W'(0), awb_pkg::POS_W'(0));
			render_if_safe(awb_pkg::POS_W'(1), awb_pkg::POS_W'(1));
			render_if_safe(awb_pkg::POS_W'(1023), awb_pkg::POS_W'(1023));
			render_if_safe(awb_pkg::POS_W'(0), awb_pkg::POS_W'(1023));
			render_if_safe(awb_pkg::POS_W'(1023), awb_pkg::POS_W'(0));
			send_word(awb_pkg::CMD_LOAD, awb_pkg::POS_W'(1023), awb_pkg::POS_W'(1023),
				32'hA5A5A5A5);
			send_word(awb_pkg::CMD_LOAD, awb_pkg::POS_W'(256), awb_pkg::POS_W'(0),
				32'h5A5A5A5A);
		end
		for (int k = 0; k < 70; k++) begin
			if ($urandom_range(0, 99) < 6)
				send_word(awb_pkg::CMD_LOAD, awb_pkg::POS_W'($urandom_range(0, 1023)),
					awb_pkg::POS_W'($urandom_range(0, 1023)), $urandom());
			else if ($urandom_range(0, 99) < 85)
				render_if_safe(awb_pkg::POS_W'($urandom_range(0, 15)),
					awb_pkg::POS_W'($urandom_range(0, 15)));
			else
				render_if_safe(awb_pkg::POS_W'($urandom_range(0, 1023)),
					awb_pkg::POS_W'($urandom_range(0, 1023)));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		calm          = 1'b0;
		sent          = 0;
		item.valid    = 1'b0;
		item.command  = awb_pkg::CMD_LOAD;
		item.pos_x    = '0;
		item.pos_y    = '0;
		item.pixel_in = '0;
		cfg.valid     = 1'b0;
		cfg.index     = awb_pkg::REG_COEF_XX;
		cfg.data      = '0;
		result.ready  = 1'b0;
		reg_mirror = '{32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd256, 32'd256};
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < 60 && sent < 1150; p++)
			run_phase(p);
		@(negedge clk);
		item.valid <= 1'b0;
		calm = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		$display("Covered %0d words: %0d loads, %0d renders of which %0d fell inside the source.",
			sent, loads, renders, inside_hits);
		$display("Mismatches reported: %0d.", errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== affine_warp_bilinear_top.f =====
hdl/awb_pkg.sv
hdl/awb_if.sv
hdl/awb_ram.sv
hdl/awb_front.sv
hdl/awb_fifo.sv
hdl/awb_back.sv
hdl/affine_warp_bilinear_top.sv
hdl/awb_checker.sv
tb/warp_checker.sv
tb/tb_top.sv
